@@ rtl/core/vtdi_pkg.sv @@
`default_nettype none

package vtdi_pkg;

  // one stored corner: position, texture and normal attribute indexes
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] tex;
    logic [15:0] nrm;
  } tuple_t;

  localparam int TUPLE_W = 48;
  localparam int INDEX_W = 24;
  localparam int MODE_W  = 2;

  // attr_mode bits
  localparam int MODE_NRM_BIT = 0;
  localparam int MODE_TEX_BIT = 1;

  localparam logic [MODE_W-1:0]  MODE_RESET = 2'd3;
  localparam logic [INDEX_W-1:0] COUNT_MAX  = 24'hFFFFFF;

  typedef enum logic [1:0] {
    STAT_MATCH = 2'd0,
    STAT_NEW   = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/vtdi_tuple_ram.sv @@
`default_nettype none

// single port pair tuple store, registered read data
module vtdi_tuple_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [ADDR_W-1:0]     wr_addr,
  input  wire vtdi_pkg::tuple_t wr_data,
  input  wire                  rd_en,
  input  wire [ADDR_W-1:0]     rd_addr,
  output vtdi_pkg::tuple_t     rd_data
);
  import vtdi_pkg::*;

  tuple_t mem [DEPTH];
  tuple_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/vtdi_tuple_match.sv @@
`default_nettype none

// compare a stored tuple with the request under the attribute mode
module vtdi_tuple_match (
  input  wire vtdi_pkg::tuple_t             stored,
  input  wire vtdi_pkg::tuple_t             probe,
  input  wire [vtdi_pkg::MODE_W-1:0]        mode,
  output logic                              hit
);
  import vtdi_pkg::*;

  logic nrm_ok;
  logic tex_ok;

  assign nrm_ok = !mode[MODE_NRM_BIT] || (stored.nrm == probe.nrm);
  assign tex_ok = !mode[MODE_TEX_BIT] || (stored.tex == probe.tex);
  assign hit    = (stored.pos == probe.pos) && nrm_ok && tex_ok;

endmodule

`default_nettype wire

@@ rtl/core/vertex_tuple_dedup_indexer_unit.sv @@
`default_nettype none

// vertex tuple dedup indexer: takes one face corner per request (position,
// texture and normal index) while busy is low and start is high, and returns
// exactly one result on out_valid for it. the corner is looked up
// in this mesh's table of unique tuples, lowest entry first, one entry per
// cycle through the read port of the tuple memory; attr_mode picks which
// attributes must agree (bit 0 normal, bit 1 texture, position always).
// a hit returns mesh base plus the entry number with status 0; a miss stores
// the tuple, returns the running global count with status 1; a full table or
// a saturated global count returns index 0 with status 2 and changes nothing.
// in_new_mesh empties the table and starts the mesh at the global count.
// the time to a result is set by the memory scan: a hit ends the scan at its
// entry, while a miss first compares every valid entry of the mesh.
// the receiver cannot stall: out_valid is a one-cycle strobe, and busy stays
// high until that strobe, so a new request can be taken in the strobe's own cycle.
// write cfg_wdata only while busy is low; it takes effect on the next request
module vertex_tuple_dedup_indexer_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] in_vertex_index,
  input  wire  [15:0] in_uv_index,
  input  wire  [15:0] in_normal_index,
  input  wire         in_new_mesh,
  // result channel
  output logic        out_valid,
  output logic [23:0] out_index,
  output logic [1:0]  out_status,
  // configuration
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_wdata
);
  import vtdi_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE
  } state_t;

  state_t               state_r;
  logic [MODE_W-1:0]    mode_r;
  logic [CNT_W-1:0]     ucount_r;     // valid entries in this mesh
  logic [INDEX_W-1:0]   total_r;      // next global output index
  logic [INDEX_W-1:0]   base_r;       // global index of the mesh's first entry
  tuple_t               probe_r;      // corner being looked up
  logic [CNT_W-1:0]     iss_r;        // next entry to read
  logic [ADDR_W-1:0]    cmp_r;        // entry whose data is on the read port
  logic                 rd_pend_r;    // read data valid this cycle
  logic                 out_valid_r;
  logic [INDEX_W-1:0]   out_index_r;
  status_t              out_status_r;

  logic                 accept;
  logic [CNT_W-1:0]     eff_count;
  logic                 rd_en;
  logic                 wr_en;
  tuple_t               rd_data;
  tuple_t               in_tuple;
  logic                 hit;
  logic                 last_cmp;
  logic                 no_room;

  assign accept    = start && (state_r == ST_IDLE);
  assign eff_count = in_new_mesh ? '0 : ucount_r;

  assign in_tuple.pos = in_vertex_index;
  assign in_tuple.tex = in_uv_index;
  assign in_tuple.nrm = in_normal_index;

  // keep issuing reads one entry ahead of the compare
  assign rd_en    = (state_r == ST_SEARCH) && (iss_r < ucount_r);
  assign last_cmp = ((CNT_W'(cmp_r) + CNT_ONE) == ucount_r);
  assign no_room  = (ucount_r == CNT_FULL) || (total_r == COUNT_MAX);
  assign wr_en    = (state_r == ST_DECIDE) && !no_room;

  vtdi_tuple_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ucount_r[ADDR_W-1:0]),
    .wr_data (probe_r),
    .rd_en   (rd_en),
    .rd_addr (iss_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  vtdi_tuple_match u_match (
    .stored (rd_data),
    .probe  (probe_r),
    .mode   (mode_r),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RESET;
      ucount_r    <= '0;
      total_r     <= '0;
      base_r      <= '0;
      iss_r       <= '0;
      cmp_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_pend_r   <= rd_en;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            probe_r <= in_tuple;
            iss_r   <= '0;
            cmp_r   <= '0;
            if (in_new_mesh) begin
              ucount_r <= '0;
              base_r   <= total_r;
            end
            // empty table goes straight to the store decision
            state_r <= (eff_count == '0) ? ST_DECIDE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rd_en) begin
            iss_r <= iss_r + CNT_ONE;
          end
          if (rd_pend_r) begin
            if (hit) begin
              out_valid_r  <= 1'b1;
              out_index_r  <= base_r + INDEX_W'(cmp_r);
              out_status_r <= STAT_MATCH;
              state_r      <= ST_IDLE;
            end else if (last_cmp) begin
              state_r <= ST_DECIDE;
            end else begin
              cmp_r <= cmp_r + ADDR_W'(1);
            end
          end
        end
        ST_DECIDE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
          if (no_room) begin
            out_index_r  <= '0;
            out_status_r <= STAT_FULL;
          end else begin
            out_index_r  <= total_r;
            out_status_r <= STAT_NEW;
            ucount_r     <= ucount_r + CNT_ONE;
            total_r      <= total_r + INDEX_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire
